[rtl/ttsb_pkg.sv]
// ----------------------------------------------------------------------------
// ttsb_pkg
// Types, constants and helpers shared by the text terminal screen buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttsb_pkg;

  localparam int ROWS   = 4;
  localparam int COLS   = 20;
  localparam int CELLS  = ROWS * COLS;
  localparam int ROW_W  = 2;
  localparam int COL_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] ESCAPE_RESET   = 8'd27;

  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLS - 1);
  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] BOTTOM_A   = ADDR_W'((ROWS - 1) * COLS);
  localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'((ROWS - 1) * COLS - 1);
  localparam logic [ADDR_W-1:0] CLEAR_END  = ADDR_W'(CELLS - 1);

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [CHAR_W-1:0] key_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic home;
    logic key_apply;
    logic ptr_zero;
    logic ptr_bottom;
    logic ptr_inc;
    logic wr_blank;
    logic rd_src;
    logic wr_copy;
    logic rd_cell;
    logic respond;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic is_escape;
    logic nl_scroll;
    logic scroll_end;
    logic clear_end;
  } stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * COLS_A;
    return base + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

[rtl/ttsb_ctrl.sv]
// ----------------------------------------------------------------------------
// ttsb_ctrl
// Sequencer for the screen buffer: decodes a request and walks the cell
// store for clear and scroll passes.
// ----------------------------------------------------------------------------
`default_nettype none

module ttsb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire ttsb_pkg::stat_t stat,
  output ttsb_pkg::cmd_t     cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_CLEAR  = 7'b0000100,
    S_SCR_RD = 7'b0001000,
    S_SCR_WR = 7'b0010000,
    S_READ   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   item_open, item_open_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      item_open <= 1'b0;
    end else begin
      state     <= state_next;
      item_open <= item_open_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    item_open_next = item_open;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture    = 1'b1;
          item_open_next = 1'b1;
          state_next     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_read) begin
          cmd.rd_cell = 1'b1;
          state_next  = S_READ;
        end else if (stat.is_escape) begin
          cmd.home     = 1'b1;
          cmd.ptr_zero = 1'b1;
          state_next   = S_CLEAR;
        end else if (stat.nl_scroll) begin
          cmd.key_apply = 1'b1;
          cmd.ptr_zero  = 1'b1;
          state_next    = S_SCR_RD;
        end else begin
          cmd.key_apply = 1'b1;
          state_next    = S_RESP;
        end
      end
      S_SCR_RD: begin
        cmd.rd_src = 1'b1;
        state_next = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd.wr_copy = 1'b1;
        if (stat.scroll_end) begin
          cmd.ptr_bottom = 1'b1;
          state_next     = S_CLEAR;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_SCR_RD;
        end
      end
      S_CLEAR: begin
        cmd.wr_blank = 1'b1;
        cmd.ptr_inc  = 1'b1;
        if (stat.clear_end) begin
          state_next = item_open ? S_RESP : S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        cmd.respond    = 1'b1;
        item_open_next = 1'b0;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/ttsb_dp.sv]
// ----------------------------------------------------------------------------
// ttsb_dp
// Datapath of the screen buffer: cell store, cursor, escape code register,
// sweep pointer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttsb_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ttsb_pkg::req_t               req,
  input  wire logic                         cfg_we,
  input  wire logic [ttsb_pkg::CHAR_W-1:0]  cfg_wdata,
  input  wire ttsb_pkg::cmd_t               cmd,
  output ttsb_pkg::stat_t                   stat,
  output logic                              done,
  output ttsb_pkg::res_t                    res
);

  logic [ttsb_pkg::CHAR_W-1:0] mem [ttsb_pkg::CELLS];
  logic [ttsb_pkg::CHAR_W-1:0] rd_data;

  ttsb_pkg::req_t              req_q;
  logic [ttsb_pkg::CHAR_W-1:0] esc_code;
  logic [ttsb_pkg::ROW_W-1:0]  cur_row, cur_row_next;
  logic [ttsb_pkg::COL_W-1:0]  cur_col, cur_col_next;
  logic [ttsb_pkg::ADDR_W-1:0] ptr;

  logic                        is_bs, is_nl, last_row, in_range;
  logic                        key_wr;
  logic [ttsb_pkg::ADDR_W-1:0] key_addr;
  logic [ttsb_pkg::CHAR_W-1:0] key_data;

  logic                        wr_en, rd_en;
  logic [ttsb_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [ttsb_pkg::CHAR_W-1:0] wr_data;

  assign is_bs    = (req_q.key_code == ttsb_pkg::CODE_BACKSPACE);
  assign is_nl    = (req_q.key_code == ttsb_pkg::CODE_NEWLINE);
  assign last_row = (cur_row == ttsb_pkg::LAST_ROW);
  assign in_range = (int'(req_q.read_row) < ttsb_pkg::ROWS) &&
                    (int'(req_q.read_col) < ttsb_pkg::COLS);

  assign stat.is_read    = (req_q.req_type == ttsb_pkg::REQ_READ);
  assign stat.is_escape  = (req_q.key_code == esc_code);
  assign stat.nl_scroll  = is_nl && last_row;
  assign stat.scroll_end = (ptr == ttsb_pkg::SCROLL_END);
  assign stat.clear_end  = (ptr == ttsb_pkg::CLEAR_END);

  // cursor motion and cell write of a non-escape key
  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    key_wr       = 1'b0;
    key_addr     = ttsb_pkg::cell_addr(cur_row, cur_col);
    key_data     = req_q.key_code;
    if (is_bs) begin
      if (cur_col == '0) begin
        cur_col_next = ttsb_pkg::LAST_COL;
        if (cur_row != '0) begin
          cur_row_next = cur_row - ttsb_pkg::ROW_W'(1);
        end
      end else begin
        cur_col_next = cur_col - ttsb_pkg::COL_W'(1);
      end
      key_wr   = 1'b1;
      key_addr = ttsb_pkg::cell_addr(cur_row_next, cur_col_next);
      key_data = ttsb_pkg::CODE_SPACE;
    end else if (is_nl) begin
      cur_col_next = '0;
      if (!last_row) begin
        cur_row_next = cur_row + ttsb_pkg::ROW_W'(1);
      end
    end else begin
      key_wr = 1'b1;
      if (cur_col == ttsb_pkg::LAST_COL) begin
        cur_col_next = '0;
        cur_row_next = last_row ? '0 : cur_row + ttsb_pkg::ROW_W'(1);
      end else begin
        cur_col_next = cur_col + ttsb_pkg::COL_W'(1);
      end
    end
  end

  // store port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = ttsb_pkg::CODE_SPACE;
    if (cmd.wr_blank) begin
      wr_en = 1'b1;
    end else if (cmd.wr_copy) begin
      wr_en   = 1'b1;
      wr_data = rd_data;
    end else if (cmd.key_apply && key_wr) begin
      wr_en   = 1'b1;
      wr_addr = key_addr;
      wr_data = key_data;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr + ttsb_pkg::COLS_A;
    if (cmd.rd_src) begin
      rd_en = 1'b1;
    end else if (cmd.rd_cell && in_range) begin
      rd_en   = 1'b1;
      rd_addr = ttsb_pkg::cell_addr(req_q.read_row, req_q.read_col);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.respond) begin
      res.cell_char  <= (stat.is_read && in_range) ? rd_data : '0;
      res.cursor_row <= cur_row;
      res.cursor_col <= cur_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_code <= ttsb_pkg::ESCAPE_RESET;
      cur_row  <= '0;
      cur_col  <= '0;
      ptr      <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.respond;
      if (cfg_we) begin
        esc_code <= cfg_wdata;
      end
      if (cmd.home) begin
        cur_row <= '0;
        cur_col <= '0;
      end else if (cmd.key_apply) begin
        cur_row <= cur_row_next;
        cur_col <= cur_col_next;
      end
      if (cmd.ptr_zero) begin
        ptr <= '0;
      end else if (cmd.ptr_bottom) begin
        ptr <= ttsb_pkg::BOTTOM_A;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + ttsb_pkg::ADDR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/text_terminal_screen_buffer.sv]
// ----------------------------------------------------------------------------
// text_terminal_screen_buffer
// 4x20 character screen with cursor, driven by key events and cell reads.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result is
// registered on res and held, with done high for a single cycle, and cannot
// be held off. A read passes decode, store read and respond; plain keys,
// backspace and newline pass decode and respond. The escape code clears all
// 80 cells one per cycle through the single write port of the store; a
// newline on the last row copies 60 cells through the read and write ports,
// then blanks 20. After reset busy stays high for a clearing pass of all 80
// cells; escape_code writes through cfg_we are taken at any time.
`default_nettype none

module text_terminal_screen_buffer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire ttsb_pkg::req_t               req,
  input  wire logic                         cfg_we,
  input  wire logic [ttsb_pkg::CHAR_W-1:0]  cfg_wdata,
  output logic                              done,
  output ttsb_pkg::res_t                    res
);

  ttsb_pkg::cmd_t  cmd;
  ttsb_pkg::stat_t stat;

  ttsb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ttsb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .res       (res)
  );

endmodule

`default_nettype wire
